/* hdl/assert_macros.svh */
// Concurrent assertion helpers shared by the RTL.
// Both forms are clocked on the given clock and turned off while the reset is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition must never be true at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

/* hdl/bisv_pkg.sv */
`timescale 1ns / 1ps

package bisv_pkg;

    // Field and counter widths
    localparam int WORD_W     = 32;
    localparam int REG_W      = 24;
    localparam int INDEX_BITS = 24;
    localparam int CMP_W      = ((INDEX_BITS > REG_W) ? INDEX_BITS : REG_W) + 1;
    localparam int FIT_W      = ((WORD_W > CMP_W) ? WORD_W : CMP_W) + 2;
    localparam int CFG_IDX_W  = 1;
    localparam int STATUS_W   = 3;

    // Register reset values
    localparam logic [REG_W-1:0] IMAGE_WORDS_RST     = REG_W'(2560);
    localparam logic [REG_W-1:0] MIN_IMAGE_WORDS_RST = REG_W'(2560);

    // Header bytes, least significant first
    localparam logic [7:0] MAGIC_LO = 8'h43;  // 'C'
    localparam logic [7:0] MAGIC_HI = 8'h59;  // 'Y'
    localparam logic [7:0] BUS_CFG  = 8'h1c;
    localparam logic [7:0] IMG_TYPE = 8'hb0;

    // Room that must remain after a section: zero-length word plus entry and checksum
    localparam int FIT_SPARE = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WORDS     = CFG_IDX_W'(0),
        CFG_MIN_IMAGE_WORDS = CFG_IDX_W'(1)
    } t_cfg_reg;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_TOO_SMALL = 3'd1,
        ST_BAD_MAGIC = 3'd2,
        ST_BAD_BUS   = 3'd3,
        ST_BAD_TYPE  = 3'd4,
        ST_SECTION   = 3'd5,
        ST_CHECKSUM  = 3'd6
    } t_status;

    typedef struct packed {
        logic [REG_W-1:0] image_words;
        logic [REG_W-1:0] min_image_words;
    } t_cfg;

    typedef struct packed {
        t_status           status;
        logic [WORD_W-1:0] computed_sum;
        logic [WORD_W-1:0] entry_address;
        logic              trailing_data;
    } t_verdict;

endpackage

/* hdl/bisv_stream_if.sv */
`timescale 1ns / 1ps

// Image word channel
interface bisv_word_if;
    logic                         valid;
    logic                         ready;
    logic [bisv_pkg::WORD_W-1:0]  image_word;

    modport source (output valid, output image_word, input ready);
    modport sink   (input valid, input image_word, output ready);
endinterface

// Verdict channel
interface bisv_verdict_if;
    logic                          valid;
    logic                          ready;
    logic [bisv_pkg::STATUS_W-1:0] status;
    logic [bisv_pkg::WORD_W-1:0]   computed_sum;
    logic [bisv_pkg::WORD_W-1:0]   entry_address;
    logic                          trailing_data;

    modport source (output valid, output status, output computed_sum,
                    output entry_address, output trailing_data, input ready);
    modport sink   (input valid, input status, input computed_sum,
                    input entry_address, input trailing_data, output ready);
endinterface

// Register write channel
interface bisv_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [bisv_pkg::CFG_IDX_W-1:0] index;
    logic [bisv_pkg::REG_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* hdl/bisv_parser.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bisv_parser (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_step,
    input  logic [bisv_pkg::WORD_W-1:0] i_word,
    input  bisv_pkg::t_cfg              i_cfg,
    output logic                        o_emit,
    output bisv_pkg::t_verdict          o_verdict
);

    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_LENGTH = 3'd1,
        PH_ADDR   = 3'd2,
        PH_DATA   = 3'd3,
        PH_ENTRY  = 3'd4,
        PH_CHECK  = 3'd5,
        PH_DONE   = 3'd6
    } t_phase;

    t_phase                              r_phase, n_phase;
    logic [bisv_pkg::INDEX_BITS-1:0]     r_idx, n_idx;
    logic [bisv_pkg::REG_W-1:0]          r_left, n_left;
    logic [bisv_pkg::WORD_W-1:0]         r_pend, n_pend;
    logic [bisv_pkg::WORD_W-1:0]         r_sum, n_sum;
    logic [bisv_pkg::WORD_W-1:0]         r_entry, n_entry;

    logic                                w_last;
    logic                                w_fit_fail;
    logic [bisv_pkg::FIT_W-1:0]          w_fit_end;
    bisv_pkg::t_status                   w_status;
    logic                                w_trailing;

    // Image boundary and section fit
    assign w_last = (bisv_pkg::CMP_W'(r_idx) + bisv_pkg::CMP_W'(1))
                    >= bisv_pkg::CMP_W'(i_cfg.image_words);
    assign w_fit_end = bisv_pkg::FIT_W'(r_idx) + bisv_pkg::FIT_W'(bisv_pkg::FIT_SPARE)
                     + bisv_pkg::FIT_W'(r_pend);
    assign w_fit_fail = w_fit_end >= bisv_pkg::FIT_W'(i_cfg.image_words);

    // Parse one word
    always_comb begin
        n_phase    = r_phase;
        n_left     = r_left;
        n_pend     = r_pend;
        n_sum      = r_sum;
        n_entry    = r_entry;
        o_emit     = 1'b0;
        w_status   = bisv_pkg::ST_OK;
        w_trailing = 1'b0;

        unique case (r_phase)
            PH_HEADER: begin
                o_emit = 1'b1;
                if (i_cfg.image_words < i_cfg.min_image_words) begin
                    w_status = bisv_pkg::ST_TOO_SMALL;
                end else if (i_word[7:0] != bisv_pkg::MAGIC_LO
                             || i_word[15:8] != bisv_pkg::MAGIC_HI) begin
                    w_status = bisv_pkg::ST_BAD_MAGIC;
                end else if (i_word[23:16] != bisv_pkg::BUS_CFG) begin
                    w_status = bisv_pkg::ST_BAD_BUS;
                end else if (i_word[31:24] != bisv_pkg::IMG_TYPE) begin
                    w_status = bisv_pkg::ST_BAD_TYPE;
                end else begin
                    o_emit  = 1'b0;
                    n_phase = PH_LENGTH;
                end
            end
            PH_LENGTH: begin
                if (i_word == '0) begin
                    n_phase = PH_ENTRY;
                end else begin
                    n_pend  = i_word;
                    n_phase = PH_ADDR;
                end
            end
            PH_ADDR: begin
                if (w_fit_fail) begin
                    o_emit   = 1'b1;
                    w_status = bisv_pkg::ST_SECTION;
                end else begin
                    n_left  = r_pend[bisv_pkg::REG_W-1:0];
                    n_phase = (r_pend[bisv_pkg::REG_W-1:0] == '0) ? PH_LENGTH : PH_DATA;
                end
            end
            PH_DATA: begin
                n_sum  = r_sum + i_word;
                n_left = r_left - bisv_pkg::REG_W'(1);
                if (n_left == '0) begin
                    n_phase = PH_LENGTH;
                end
            end
            PH_ENTRY: begin
                n_entry = i_word;
                n_phase = PH_CHECK;
            end
            PH_CHECK: begin
                o_emit     = 1'b1;
                w_status   = (r_sum == i_word) ? bisv_pkg::ST_OK : bisv_pkg::ST_CHECKSUM;
                w_trailing = !w_last;
            end
            PH_DONE: begin
            end
            default: begin
            end
        endcase

        // Image ran out before a verdict
        if (!o_emit && w_last && n_phase != PH_DONE) begin
            o_emit   = 1'b1;
            w_status = (n_phase == PH_ENTRY || n_phase == PH_CHECK)
                     ? bisv_pkg::ST_CHECKSUM : bisv_pkg::ST_SECTION;
        end
        if (o_emit) begin
            n_phase = PH_DONE;
        end

        o_verdict.status        = w_status;
        o_verdict.computed_sum  = n_sum;
        o_verdict.entry_address = n_entry;
        o_verdict.trailing_data = w_trailing;

        // Return to header state at the image end
        if (w_last) begin
            n_phase = PH_HEADER;
            n_idx   = '0;
            n_left  = '0;
            n_pend  = '0;
            n_sum   = '0;
            n_entry = '0;
        end else begin
            n_idx = r_idx + bisv_pkg::INDEX_BITS'(1);
        end
    end

    // Hold parse state, advance on each consumed word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER;
            r_idx   <= '0;
            r_left  <= '0;
            r_pend  <= '0;
            r_sum   <= '0;
            r_entry <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_idx   <= n_idx;
            r_left  <= n_left;
            r_pend  <= n_pend;
            r_sum   <= n_sum;
            r_entry <= n_entry;
        end
    end

    `ASSERT_NEVER(a_done_silent, i_clk, i_rst_n, (r_phase == PH_DONE) && o_emit, "verdict after image already judged")
    `ASSERT_PROP(a_left_in_data, i_clk, i_rst_n, (r_phase == PH_DATA) == (r_left != '0), "section count out of step with phase")
    `ASSERT_PROP(a_trailing_check, i_clk, i_rst_n, o_emit && o_verdict.trailing_data |-> r_phase == PH_CHECK, "trailing flag outside checksum verdict")

endmodule

/* hdl/boot_image_section_validator.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Boot image section validator.
// i_word carries one 32-bit little-endian image word per request; the image is
// image_words words long. o_verdict gives one request per image: status,
// computed sum, entry address and the trailing-data flag. Words after the
// verdict, up to the image end, produce nothing.
// i_cfg writes image_words (index 0), min_image_words (index 1); always ready.
// The user must write it between images while the block is idle (not enforced).
// A word is registered in the input register and judged from there; the verdict
// it decides is then registered in the verdict register.
// Throughput: one word per cycle unless a verdict stalls; the parse state update
// is a single add and compare stage between the input and verdict registers.
// Reset: both registers return to 2560 words and the parser to the header.
// When the receiver stalls with a verdict pending, words that give no verdict
// keep flowing; a word that would give a second verdict waits in the input
// register and i_word.ready drops until the verdict is taken.
module boot_image_section_validator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bisv_word_if.sink   i_word,
    bisv_verdict_if.source o_verdict,
    bisv_cfg_if.sink    i_cfg
);

    bisv_pkg::t_cfg                  r_cfg;
    logic                            r_in_valid;
    logic [bisv_pkg::WORD_W-1:0]     r_in_word;
    logic                            r_out_valid;
    bisv_pkg::t_verdict              r_out;

    logic                            w_emit;
    bisv_pkg::t_verdict              w_verdict;
    logic                            w_slot_free;
    logic                            w_advance;

    // Register writes
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.image_words     <= bisv_pkg::IMAGE_WORDS_RST;
            r_cfg.min_image_words <= bisv_pkg::MIN_IMAGE_WORDS_RST;
        end else if (i_cfg.valid) begin
            unique case (bisv_pkg::t_cfg_reg'(i_cfg.index))
                bisv_pkg::CFG_IMAGE_WORDS:     r_cfg.image_words     <= i_cfg.data;
                bisv_pkg::CFG_MIN_IMAGE_WORDS: r_cfg.min_image_words <= i_cfg.data;
            endcase
        end
    end

    // Advance the stage unless a verdict has nowhere to go
    assign w_slot_free  = !r_out_valid || o_verdict.ready;
    assign w_advance    = r_in_valid && (!w_emit || w_slot_free);
    assign i_word.ready = !r_in_valid || w_advance;

    bisv_parser u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (w_advance),
        .i_word    (r_in_word),
        .i_cfg     (r_cfg),
        .o_emit    (w_emit),
        .o_verdict (w_verdict)
    );

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_word.ready) begin
            r_in_valid <= i_word.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_word.valid && i_word.ready) begin
            r_in_word <= i_word.image_word;
        end
    end

    // Verdict register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance && w_emit) begin
            r_out_valid <= 1'b1;
        end else if (o_verdict.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && w_emit) begin
            r_out <= w_verdict;
        end
    end

    assign o_verdict.valid         = r_out_valid;
    assign o_verdict.status        = r_out.status;
    assign o_verdict.computed_sum  = r_out.computed_sum;
    assign o_verdict.entry_address = r_out.entry_address;
    assign o_verdict.trailing_data = r_out.trailing_data;

    `ASSERT_PROP(a_blocked_word_held, i_clk, i_rst_n, r_in_valid && w_emit && r_out_valid && !o_verdict.ready |=> r_in_valid && $stable(r_in_word), "blocked word lost from input stage")
    `ASSERT_NEVER(a_no_overwrite, i_clk, i_rst_n, w_advance && w_emit && r_out_valid && !o_verdict.ready, "pending verdict overwritten")
    `ASSERT_PROP(a_verdict_held, i_clk, i_rst_n, r_out_valid && !o_verdict.ready |=> r_out_valid && $stable(r_out), "verdict changed while stalled")

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int DRAIN_CYCLES   = 10;
    localparam int PHASES         = 12;
    localparam int PHASE_WORDS    = 150;
    localparam int SHOW_LIMIT     = 10;

    localparam logic [bisv_pkg::WORD_W-1:0] GOOD_HDR = {bisv_pkg::IMG_TYPE, bisv_pkg::BUS_CFG,
                                                        bisv_pkg::MAGIC_HI, bisv_pkg::MAGIC_LO};

    typedef enum {
        P_HEADER, P_LENGTH, P_ADDR, P_DATA, P_ENTRY, P_CHECK, P_DONE
    } t_parse;

    typedef enum {IMG_CLEAN, IMG_CORRUPT, IMG_NOISE} t_img_kind;

    // Predict verdicts from the accepted word stream and compare them in order
    class t_verdict_predictor;
        logic [bisv_pkg::REG_W-1:0]      image_words;
        logic [bisv_pkg::REG_W-1:0]      min_words;
        t_parse                          phase;
        logic [bisv_pkg::INDEX_BITS-1:0] word_idx;
        logic [bisv_pkg::REG_W-1:0]      words_left;
        logic [bisv_pkg::WORD_W-1:0]     section_len;
        logic [bisv_pkg::WORD_W-1:0]     data_sum;
        logic [bisv_pkg::WORD_W-1:0]     entry_word;
        bisv_pkg::t_verdict              pending_verdicts[$];
        int                              errors;
        int                              shown;

        function new();
            image_words = bisv_pkg::IMAGE_WORDS_RST;
            min_words   = bisv_pkg::MIN_IMAGE_WORDS_RST;
            errors      = 0;
            shown       = 0;
            clear_image();
        endfunction

        function void clear_image();
            phase       = P_HEADER;
            word_idx    = '0;
            words_left  = '0;
            section_len = '0;
            data_sum    = '0;
            entry_word  = '0;
        endfunction

        function void write_reg(bisv_pkg::t_cfg_reg r, logic [bisv_pkg::REG_W-1:0] val);
            case (r)
                bisv_pkg::CFG_IMAGE_WORDS:     image_words = val;
                bisv_pkg::CFG_MIN_IMAGE_WORDS: min_words = val;
                default: ;
            endcase
        endfunction

        function int outstanding();
            return pending_verdicts.size();
        endfunction

        // Advance the parser by one accepted word
        function void note_word(logic [bisv_pkg::WORD_W-1:0] w);
            longint unsigned    pos;
            longint unsigned    lim;
            logic               last;
            logic               emit;
            logic               trail;
            bisv_pkg::t_status  st;
            bisv_pkg::t_verdict v;
            pos   = word_idx;
            lim   = image_words;
            last  = (pos + 1) >= lim;
            emit  = 1'b0;
            trail = 1'b0;
            st    = bisv_pkg::ST_OK;
            case (phase)
                P_HEADER: begin
                    emit = 1'b1;
                    if (image_words < min_words)
                        st = bisv_pkg::ST_TOO_SMALL;
                    else if (w[7:0] != bisv_pkg::MAGIC_LO || w[15:8] != bisv_pkg::MAGIC_HI)
                        st = bisv_pkg::ST_BAD_MAGIC;
                    else if (w[23:16] != bisv_pkg::BUS_CFG)
                        st = bisv_pkg::ST_BAD_BUS;
                    else if (w[31:24] != bisv_pkg::IMG_TYPE)
                        st = bisv_pkg::ST_BAD_TYPE;
                    else begin
                        emit  = 1'b0;
                        phase = P_LENGTH;
                    end
                end
                P_LENGTH: begin
                    if (w == '0) begin
                        phase = P_ENTRY;
                    end else begin
                        section_len = w;
                        phase       = P_ADDR;
                    end
                end
                P_ADDR: begin
                    // Section must leave room for the entry and checksum words
                    if (pos + 1 + section_len + 2 >= lim) begin
                        emit = 1'b1;
                        st   = bisv_pkg::ST_SECTION;
                    end else begin
                        words_left = section_len[bisv_pkg::REG_W-1:0];
                        phase      = (words_left == '0) ? P_LENGTH : P_DATA;
                    end
                end
                P_DATA: begin
                    data_sum   = data_sum + w;
                    words_left = words_left - 1'b1;
                    if (words_left == '0)
                        phase = P_LENGTH;
                end
                P_ENTRY: begin
                    entry_word = w;
                    phase      = P_CHECK;
                end
                P_CHECK: begin
                    emit  = 1'b1;
                    st    = (data_sum == w) ? bisv_pkg::ST_OK : bisv_pkg::ST_CHECKSUM;
                    trail = !last;
                end
                default: ;
            endcase

            // Image ran out before a verdict
            if (!emit && last && phase != P_DONE) begin
                emit = 1'b1;
                st   = (phase == P_ENTRY || phase == P_CHECK) ? bisv_pkg::ST_CHECKSUM
                                                              : bisv_pkg::ST_SECTION;
            end

            if (emit) begin
                v.status        = st;
                v.computed_sum  = data_sum;
                v.entry_address = entry_word;
                v.trailing_data = trail;
                pending_verdicts.push_back(v);
                phase = P_DONE;
            end

            if (last)
                clear_image();
            else
                word_idx = word_idx + 1'b1;
        endfunction

        function void check_verdict(bisv_pkg::t_verdict got);
            bisv_pkg::t_verdict exp;
            if (pending_verdicts.size() == 0) begin
                errors++;
                if (shown < SHOW_LIMIT)
                    $display("[%0t] verdict with none pending: status %0d sum %h entry %h trail %0b",
                             $realtime, got.status, got.computed_sum, got.entry_address,
                             got.trailing_data);
                shown++;
                return;
            end
            exp = pending_verdicts.pop_front();
            if (got.status !== exp.status || got.computed_sum !== exp.computed_sum ||
                got.entry_address !== exp.entry_address ||
                got.trailing_data !== exp.trailing_data) begin
                errors++;
                if (shown < SHOW_LIMIT)
                    $display({"[%0t] verdict mismatch: status %0d/%0d sum %h/%h entry %h/%h ",
                              "trail %0b/%0b (expected/actual)"}, $realtime,
                             exp.status, got.status, exp.computed_sum, got.computed_sum,
                             exp.entry_address, got.entry_address,
                             exp.trailing_data, got.trailing_data);
                shown++;
            end
        endfunction

        function void close_out();
            errors += pending_verdicts.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    bisv_word_if    word_ch();
    bisv_verdict_if verdict_ch();
    bisv_cfg_if     cfg_ch();

    boot_image_section_validator dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_word   (word_ch),
        .o_verdict(verdict_ch),
        .i_cfg    (cfg_ch)
    );

    t_verdict_predictor verdicts = new();

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int words_sent    = 0;
    int verdicts_seen = 0;
    int reg_writes    = 0;
    int quiet_cycles  = 0;
    int status_seen[8];

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Hold all inputs at known values from time zero
    initial begin
        i_rst_n            = 1'b0;
        word_ch.valid      = 1'b0;
        word_ch.image_word = '0;
        verdict_ch.ready   = 1'b0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.index       = bisv_pkg::CFG_IMAGE_WORDS;
        cfg_ch.data        = '0;
        foreach (status_seen[i]) status_seen[i] = 0;
    end

    // Stall the verdict receiver at random
    always @(posedge i_clk)
        verdict_ch.ready <= ($urandom_range(0, 99) >= stall_pct);

    // Check each accepted verdict
    always @(posedge i_clk) begin : verdict_monitor
        bisv_pkg::t_verdict got;
        if (i_rst_n && verdict_ch.valid && verdict_ch.ready) begin
            got.status        = bisv_pkg::t_status'(verdict_ch.status);
            got.computed_sum  = verdict_ch.computed_sum;
            got.entry_address = verdict_ch.entry_address;
            got.trailing_data = verdict_ch.trailing_data;
            status_seen[verdict_ch.status]++;
            verdicts_seen++;
            verdicts.check_verdict(got);
        end
    end

    // Abort when no request moves on any channel for too long
    always @(posedge i_clk) begin
        if ((word_ch.valid && word_ch.ready) || (verdict_ch.valid && verdict_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired after %0d quiet cycles", quiet_cycles);
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic send_word(input logic [bisv_pkg::WORD_W-1:0] w);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            word_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        word_ch.valid      <= 1'b1;
        word_ch.image_word <= w;
        do @(posedge i_clk); while (!word_ch.ready);
        verdicts.note_word(w);
        words_sent++;
    endtask

    task automatic stream_image(ref logic [bisv_pkg::WORD_W-1:0] img[$]);
        foreach (img[i]) send_word(img[i]);
    endtask

    // Write a register once every verdict is in and the pipeline has drained
    task automatic write_reg(input bisv_pkg::t_cfg_reg r,
                             input logic [bisv_pkg::REG_W-1:0] val);
        word_ch.valid <= 1'b0;
        while (verdicts.outstanding() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= r;
        cfg_ch.data  <= val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        verdicts.write_reg(r, val);
        reg_writes++;
        cfg_ch.valid <= 1'b0;
    endtask

    // Assemble one image of n words: header, sections, trailer, padding
    task automatic build_image(input int n, input t_img_kind kind,
                               ref logic [bisv_pkg::WORD_W-1:0] img[$]);
        int                          room;
        int                          len;
        int                          at;
        bit                          oversize;
        logic [bisv_pkg::WORD_W-1:0] sum;
        logic [bisv_pkg::WORD_W-1:0] w;
        logic [bisv_pkg::WORD_W-1:0] trailer[$];
        img.delete();
        sum      = '0;
        oversize = 1'b0;
        if (kind == IMG_NOISE) begin
            repeat (n) img.push_back($urandom());
            return;
        end
        img.push_back(GOOD_HDR);
        while (n - int'(img.size()) >= 6 && $urandom_range(0, 3) != 0 && !oversize) begin
            room = n - int'(img.size()) - 5;
            if ($urandom_range(0, 9) == 0) begin
                // one word too long for the fit check
                len      = room + 1;
                oversize = 1'b1;
            end else if ($urandom_range(0, 3) == 0) begin
                len = room;
            end else begin
                len = $urandom_range(1, (room < 8) ? room : 8);
            end
            img.push_back(bisv_pkg::WORD_W'(len));
            img.push_back($urandom());
            if (!oversize) begin
                repeat (len) begin
                    w   = $urandom();
                    sum = sum + w;
                    img.push_back(w);
                end
            end
        end
        if (!oversize) begin
            trailer = '{32'h0, $urandom(),
                        ($urandom_range(0, 5) == 0) ? sum ^ (32'h1 << $urandom_range(0, 31)) : sum};
            foreach (trailer[i])
                if (img.size() < n) img.push_back(trailer[i]);
        end
        while (img.size() < n) img.push_back($urandom());
        if (kind == IMG_CORRUPT) begin
            at = $urandom_range(0, n - 1);
            if ($urandom_range(0, 1) == 0)
                img[at] = img[at] ^ (32'h1 << $urandom_range(0, 31));
            else
                img[at] = $urandom();
        end
    endtask

    initial begin : stimulus
        logic [bisv_pkg::WORD_W-1:0] img[$];
        int                          n;
        int                          minw;
        int                          phase_words;
        int                          pick;
        t_img_kind                   kind;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 27;
        stall_pct     = 27;

        // Reset minimum length rejects a one-word image
        write_reg(bisv_pkg::CFG_IMAGE_WORDS, 1);
        img = '{GOOD_HDR};
        stream_image(img);

        // Header byte checks on one-word images
        write_reg(bisv_pkg::CFG_MIN_IMAGE_WORDS, 0);
        img = '{32'h0, {bisv_pkg::IMG_TYPE, bisv_pkg::BUS_CFG, bisv_pkg::MAGIC_HI, 8'h00},
                {bisv_pkg::IMG_TYPE, bisv_pkg::BUS_CFG, 8'hff, bisv_pkg::MAGIC_LO},
                {bisv_pkg::IMG_TYPE, 8'h1d, bisv_pkg::MAGIC_HI, bisv_pkg::MAGIC_LO},
                {8'h30, bisv_pkg::BUS_CFG, bisv_pkg::MAGIC_HI, bisv_pkg::MAGIC_LO},
                GOOD_HDR, 32'hffff_ffff};
        stream_image(img);

        // Image below the minimum length
        write_reg(bisv_pkg::CFG_MIN_IMAGE_WORDS, '1);
        img = '{GOOD_HDR};
        stream_image(img);

        // Checksum word missing
        write_reg(bisv_pkg::CFG_IMAGE_WORDS, 3);
        write_reg(bisv_pkg::CFG_MIN_IMAGE_WORDS, 3);
        img = '{GOOD_HDR, 32'h0, 32'h0bad_cafe};
        stream_image(img);

        // Empty image that passes, then a checksum miss with trailing data
        write_reg(bisv_pkg::CFG_IMAGE_WORDS, 4);
        img = '{GOOD_HDR, 32'h0, 32'hffff_ffff, 32'h0};
        stream_image(img);
        write_reg(bisv_pkg::CFG_IMAGE_WORDS, 5);
        img = '{GOOD_HDR, 32'h0, 32'h0, 32'h1, 32'hffff_ffff};
        stream_image(img);

        // Section that just fits, then one word too long
        write_reg(bisv_pkg::CFG_IMAGE_WORDS, 7);
        img = '{GOOD_HDR, 32'h1, 32'h0, 32'hffff_ffff, 32'h0, 32'h8000_0000, 32'hffff_ffff};
        stream_image(img);
        img = '{GOOD_HDR, 32'h2, 32'h0, 32'h1, 32'h1, 32'h1, 32'h1};
        stream_image(img);

        // Random phases with varying sizes, limits and idling
        for (int p = 0; p < PHASES; p++) begin
            n = (p % 5 == 4) ? $urandom_range(100, 300) : $urandom_range(1, 40);
            pick = $urandom_range(0, 9);
            case (pick)
                0:       minw = 0;
                1:       minw = n;
                2:       minw = n + 1;
                3:       minw = 24'hff_ffff;
                default: minw = $urandom_range(0, n);
            endcase
            if (p == 3)
                write_reg(bisv_pkg::CFG_IMAGE_WORDS, '1);
            write_reg(bisv_pkg::CFG_IMAGE_WORDS, bisv_pkg::REG_W'(n));
            write_reg(bisv_pkg::CFG_MIN_IMAGE_WORDS, bisv_pkg::REG_W'(minw));
            case (p % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 54; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 54; end
                default: begin send_idle_pct = 27; stall_pct = 27; end
            endcase
            phase_words = 0;
            while (phase_words < PHASE_WORDS) begin
                pick = $urandom_range(0, 99);
                kind = (pick < 70) ? IMG_CLEAN : (pick < 88) ? IMG_CORRUPT : IMG_NOISE;
                build_image(n, kind, img);
                stream_image(img);
                phase_words += n;
            end
        end

        // Drain
        word_ch.valid <= 1'b0;
        while (verdicts.outstanding() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        verdicts.close_out();

        $display("Streamed %0d image words, checked %0d verdicts, %0d register writes",
                 words_sent, verdicts_seen, reg_writes);
        $display("Verdicts by status: ok %0d small %0d magic %0d bus %0d type %0d sect %0d sum %0d",
                 status_seen[bisv_pkg::ST_OK], status_seen[bisv_pkg::ST_TOO_SMALL],
                 status_seen[bisv_pkg::ST_BAD_MAGIC], status_seen[bisv_pkg::ST_BAD_BUS],
                 status_seen[bisv_pkg::ST_BAD_TYPE], status_seen[bisv_pkg::ST_SECTION],
                 status_seen[bisv_pkg::ST_CHECKSUM]);
        if (verdicts.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

/* files.f */
+incdir+hdl
hdl/bisv_pkg.sv
hdl/bisv_stream_if.sv
hdl/bisv_parser.sv
hdl/boot_image_section_validator.sv
tb/sv/tb_top.sv
